// ----- rtl/core/accil_pkg.sv -----
// ----------------------------------------------------------------------------
// accil_pkg
// Types, opcodes and status codes of the accumulator instruction executor.
// ----------------------------------------------------------------------------
`default_nettype none

package accil_pkg;

  localparam logic [4:0] OP_LD    = 5'd0;
  localparam logic [4:0] OP_LDN   = 5'd1;
  localparam logic [4:0] OP_ST    = 5'd2;
  localparam logic [4:0] OP_STN   = 5'd3;
  localparam logic [4:0] OP_READ  = 5'd4;
  localparam logic [4:0] OP_PRINT = 5'd5;
  localparam logic [4:0] OP_AND   = 5'd6;
  localparam logic [4:0] OP_NAND  = 5'd7;
  localparam logic [4:0] OP_OR    = 5'd8;
  localparam logic [4:0] OP_NOR   = 5'd9;
  localparam logic [4:0] OP_XOR   = 5'd10;
  localparam logic [4:0] OP_XNOR  = 5'd11;
  localparam logic [4:0] OP_NOT   = 5'd12;
  localparam logic [4:0] OP_ADD   = 5'd13;
  localparam logic [4:0] OP_SUB   = 5'd14;
  localparam logic [4:0] OP_MUL   = 5'd15;
  localparam logic [4:0] OP_DIV   = 5'd16;
  localparam logic [4:0] OP_GT    = 5'd17;
  localparam logic [4:0] OP_GE    = 5'd18;
  localparam logic [4:0] OP_EQ    = 5'd19;
  localparam logic [4:0] OP_NE    = 5'd20;
  localparam logic [4:0] OP_LE    = 5'd21;
  localparam logic [4:0] OP_LT    = 5'd22;
  localparam logic [4:0] OP_JMP   = 5'd23;
  localparam logic [4:0] OP_JMPC  = 5'd24;
  localparam logic [4:0] OP_JMPCN = 5'd25;
  localparam logic [4:0] OP_RET   = 5'd26;
  localparam logic [4:0] OP_RETC  = 5'd27;
  localparam logic [4:0] OP_RETCN = 5'd28;
  localparam logic [4:0] OP_LAST  = OP_RETCN;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_RET     = 3'd1;
  localparam logic [2:0] STAT_UNKNOWN = 3'd2;
  localparam logic [2:0] STAT_DIVZERO = 3'd3;
  localparam logic [2:0] STAT_HALTED  = 3'd4;

  localparam logic [1:0] PRINT_NONE  = 2'd0;
  localparam logic [1:0] PRINT_VALUE = 2'd1;
  localparam logic [1:0] PRINT_MINUS = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [4:0]         req_type;
    logic signed [63:0] operand;
    logic signed [63:0] read_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [1:0]         print_kind;
    logic signed [63:0] print_value;
    logic [15:0]        next_pc;
    logic signed [63:0] acc_value;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/accumulator_il_instruction_executor_top.sv -----
// ----------------------------------------------------------------------------
// accumulator_il_instruction_executor_top: one instruction per request.
// Throughput one request per cycle while the output is not stalled; results
// other than mul and div are registered in the cycle after acceptance. Mul
// and div hold off the next through CALC (64 accil_muldiv steps) and FIN.
// Reset clears accumulator and program counter and sets the machine running.
// ----------------------------------------------------------------------------
`default_nettype none

module accumulator_il_instruction_executor_top #(
  parameter int PC_WIDTH = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire accil_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output accil_pkg::rsp_t    out_rsp_o
);

  accil_pkg::state_e state_q, state_d;

  logic signed [63:0]  acc_q, acc_d;
  logic [PC_WIDTH-1:0] pc_q, pc_d;
  logic                run_q, run_d;
  logic                neg_q, neg_d;
  logic                isdiv_q, isdiv_d;
  logic                out_valid_q, out_valid_d;
  accil_pkg::rsp_t     rsp_q, rsp_d;

  logic                accept;
  logic                slot_free;
  logic                load_out;
  logic                long_op;

  accil_pkg::md_ctrl_t md_ctrl;
  logic                md_done;
  logic [63:0]         md_res;
  logic [63:0]         md_a;
  logic [63:0]         md_b;

  logic [4:0]          op;
  logic signed [63:0]  arg;
  logic signed [63:0]  acc_n;
  logic [PC_WIDTH-1:0] pc_n;
  logic [PC_WIDTH-1:0] pc_inc;
  logic [PC_WIDTH-1:0] pc_jmp;
  logic                run_n;
  logic [2:0]          stat_n;
  logic [1:0]          kind_n;
  logic                take;
  logic [63:0]         quot;
  logic [31:0]         pc_ext;

  assign op     = in_req_i.req_type;
  assign arg    = in_req_i.operand;
  assign pc_inc = pc_q + PC_WIDTH'(1);
  assign pc_jmp = pc_q + arg[PC_WIDTH-1:0];

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != accil_pkg::ST_IDLE) || !slot_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign long_op    = run_q && ((op == accil_pkg::OP_MUL) ||
                      ((op == accil_pkg::OP_DIV) && (arg != 64'sd0)));

  // combinational execute of all opcodes but mul and div
  always_comb begin
    acc_n  = acc_q;
    pc_n   = pc_q;
    run_n  = run_q;
    stat_n = accil_pkg::STAT_OK;
    kind_n = accil_pkg::PRINT_NONE;
    take   = 1'b0;
    if (!run_q) begin
      stat_n = accil_pkg::STAT_HALTED;
    end else if (op > accil_pkg::OP_LAST) begin
      stat_n = accil_pkg::STAT_UNKNOWN;
      run_n  = 1'b0;
    end else if ((op == accil_pkg::OP_DIV) && (arg == 64'sd0)) begin
      stat_n = accil_pkg::STAT_DIVZERO;
      run_n  = 1'b0;
    end else begin
      unique case (op)
        accil_pkg::OP_LD:    acc_n = arg;
        accil_pkg::OP_LDN:   acc_n = -arg;
        accil_pkg::OP_ST:    kind_n = accil_pkg::PRINT_VALUE;
        accil_pkg::OP_STN:   kind_n = accil_pkg::PRINT_MINUS;
        accil_pkg::OP_READ:  acc_n = in_req_i.read_value;
        accil_pkg::OP_PRINT: kind_n = accil_pkg::PRINT_VALUE;
        accil_pkg::OP_AND:   acc_n = acc_q & arg;
        accil_pkg::OP_NAND:  acc_n = ~(acc_q & arg);
        accil_pkg::OP_OR:    acc_n = acc_q | arg;
        accil_pkg::OP_NOR:   acc_n = ~(acc_q | arg);
        accil_pkg::OP_XOR:   acc_n = acc_q ^ arg;
        accil_pkg::OP_XNOR:  acc_n = ~(acc_q ^ arg);
        accil_pkg::OP_NOT:   acc_n = ~acc_q;
        accil_pkg::OP_ADD:   acc_n = acc_q + arg;
        accil_pkg::OP_SUB:   acc_n = acc_q - arg;
        accil_pkg::OP_GT:    acc_n = {63'd0, (arg < acc_q)};
        accil_pkg::OP_GE:    acc_n = {63'd0, !(acc_q < arg)};
        accil_pkg::OP_EQ:    acc_n = {63'd0, (acc_q == arg)};
        accil_pkg::OP_NE:    acc_n = {63'd0, (acc_q != arg)};
        accil_pkg::OP_LE:    acc_n = {63'd0, !(arg < acc_q)};
        accil_pkg::OP_LT:    acc_n = {63'd0, (acc_q < arg)};
        accil_pkg::OP_JMP:   take = 1'b1;
        accil_pkg::OP_JMPC:  take = (acc_q == 64'sd1);
        accil_pkg::OP_JMPCN: take = (acc_q == 64'sd0);
        accil_pkg::OP_RET:   run_n = 1'b0;
        accil_pkg::OP_RETC:  run_n = !(acc_q == 64'sd1);
        accil_pkg::OP_RETCN: run_n = !(acc_q == 64'sd0);
        default:             acc_n = acc_q;
      endcase
      pc_n = take ? pc_jmp : pc_inc;
      if (!run_n) begin
        stat_n = accil_pkg::STAT_RET;
      end
    end
  end

  // operand magnitudes for divide; multiply uses raw bits
  always_comb begin
    md_a = acc_q;
    md_b = arg;
    if (op == accil_pkg::OP_DIV) begin
      md_a = acc_q[63] ? -acc_q : acc_q;
      md_b = arg[63] ? -arg : arg;
    end
  end

  assign quot = neg_q ? -md_res : md_res;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      accil_pkg::ST_IDLE: begin
        if (accept && long_op) begin
          state_d = accil_pkg::ST_CALC;
        end
      end
      accil_pkg::ST_CALC: begin
        if (md_done) begin
          state_d = accil_pkg::ST_FIN;
        end
      end
      accil_pkg::ST_FIN: begin
        if (slot_free) begin
          state_d = accil_pkg::ST_IDLE;
        end
      end
      default: state_d = accil_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    md_ctrl  = '0;
    load_out = 1'b0;
    acc_d    = acc_q;
    pc_d     = pc_q;
    run_d    = run_q;
    neg_d    = neg_q;
    isdiv_d  = isdiv_q;
    rsp_d    = rsp_q;
    pc_ext   = '0;
    unique case (state_q)
      accil_pkg::ST_IDLE: begin
        if (accept && long_op) begin
          md_ctrl.start  = 1'b1;
          md_ctrl.is_div = (op == accil_pkg::OP_DIV);
          isdiv_d        = (op == accil_pkg::OP_DIV);
          neg_d          = acc_q[63] ^ arg[63];
        end else if (accept) begin
          load_out          = 1'b1;
          acc_d             = acc_n;
          pc_d              = pc_n;
          run_d             = run_n;
          pc_ext            = 32'(pc_n);
          rsp_d.status      = stat_n;
          rsp_d.print_kind  = kind_n;
          rsp_d.print_value = (kind_n != accil_pkg::PRINT_NONE) ? acc_n : 64'sd0;
          rsp_d.next_pc     = pc_ext[15:0];
          rsp_d.acc_value   = acc_n;
        end
      end
      accil_pkg::ST_FIN: begin
        if (slot_free) begin
          load_out          = 1'b1;
          acc_d             = isdiv_q ? quot : md_res;
          pc_d              = pc_inc;
          pc_ext            = 32'(pc_inc);
          rsp_d.status      = accil_pkg::STAT_OK;
          rsp_d.print_kind  = accil_pkg::PRINT_NONE;
          rsp_d.print_value = 64'sd0;
          rsp_d.next_pc     = pc_ext[15:0];
          rsp_d.acc_value   = isdiv_q ? quot : md_res;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  accil_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (md_ctrl),
    .a_i    (md_a),
    .b_i    (md_b),
    .done_o (md_done),
    .res_o  (md_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= accil_pkg::ST_IDLE;
      acc_q       <= '0;
      pc_q        <= '0;
      run_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      pc_q        <= pc_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    isdiv_q <= isdiv_d;
    rsp_q   <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_halt_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(run_q) |-> out_valid_q && (rsp_q.status == accil_pkg::STAT_RET ||
      rsp_q.status == accil_pkg::STAT_UNKNOWN || rsp_q.status == accil_pkg::STAT_DIVZERO))
    else $error("halt without halting status");

  a_no_start_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_ctrl.start |-> run_q)
    else $error("muldiv started while halted");

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> state_q == accil_pkg::ST_CALC)
    else $error("muldiv finished outside calc state");

endmodule

`default_nettype wire

// ----- rtl/core/accil_muldiv.sv -----
// ----------------------------------------------------------------------------
// accil_muldiv
// Radix-2 multiply / restoring divide on one shared 64-bit adder, 64 steps.
// ----------------------------------------------------------------------------
`default_nettype none

module accil_muldiv (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire accil_pkg::md_ctrl_t ctrl_i,
  input  wire  [63:0]            a_i,
  input  wire  [63:0]            b_i,
  output logic                   done_o,
  output logic [63:0]            res_o
);

  logic        busy_q, busy_d;
  logic        div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] x_q, x_d;
  logic [63:0] y_q, y_d;
  logic [63:0] z_q, z_d;

  logic [63:0] r_sh;
  logic [63:0] add_a;
  logic [63:0] add_b;
  logic [64:0] sum;

  // mul: x = product, y = multiplicand, z = multiplier
  // div: x = remainder, y = divisor, z = dividend shifting into quotient
  assign r_sh  = {x_q[62:0], z_q[63]};
  assign add_a = div_q ? r_sh : x_q;
  assign add_b = div_q ? ~y_q : y_q;
  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {64'd0, div_q};

  assign done_o = busy_q && (cnt_q == 6'd63);
  assign res_o  = div_q ? z_q : x_q;

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      div_d  = ctrl_i.is_div;
      cnt_d  = '0;
      x_d    = '0;
      y_d    = b_i;
      z_d    = a_i;
    end else if (busy_q) begin
      cnt_d = cnt_q + 6'd1;
      if (done_o) begin
        busy_d = 1'b0;
      end
      if (div_q) begin
        x_d = sum[64] ? sum[63:0] : r_sh;
        z_d = {z_q[62:0], sum[64]};
      end else begin
        x_d = z_q[0] ? sum[63:0] : x_q;
        y_d = {y_q[62:0], 1'b0};
        z_d = {1'b0, z_q[63:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

endmodule

`default_nettype wire

// ----- dv/accumulator_il_instruction_executor_top_tb.sv -----
// ----------------------------------------------------------------------------
// accumulator_il_instruction_executor_top_tb
// Self-checking bench for the accumulator instruction executor. A directed
// table covers every opcode but RET, wrap and divide extremes, conditional
// jumps taken and conditional returns not taken. It is followed by random
// instructions biased toward compare/branch pairs. The machine never halts
// until the end of the run. There, one halting case is picked at random
// (return, conditional return, unknown opcode or divide by zero) and then a
// few ignored requests follow. Every response is checked against an
// in-bench model of the machine, with random stalls and gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accumulator_il_instruction_executor_top_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 200;
  localparam int TAIL_CYCLES    = 100;
  localparam int N_RANDOM       = 1320;

  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    accil_pkg::req_t req;
    logic            pinned;
    accil_pkg::rsp_t rsp;
  } instr_row_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  accil_pkg::req_t in_req;
  logic            out_valid;
  logic            out_stall;
  accil_pkg::rsp_t out_rsp;

  logic signed [63:0] acc_q = '0;
  logic [15:0]        pc_q  = '0;
  logic               run_q = 1'b1;

  accil_pkg::rsp_t pending_rsp_q[$];
  instr_row_t      dir_tbl[$];
  int              fails = 0;
  int              hold_ticket = 0;
  logic            calm = 1'b0;
  int              tx_rate = 20;

  always #5 clk = ~clk;

  accumulator_il_instruction_executor_top #(
    .PC_WIDTH(16)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  function automatic accil_pkg::rsp_t execute_instr(input accil_pkg::req_t r);
    accil_pkg::rsp_t    o;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [63:0]        ma;
    logic [63:0]        mb;
    logic [63:0]        q;
    logic               take;
    o    = '0;
    a    = acc_q;
    b    = r.operand;
    take = 1'b0;
    if (!run_q) begin
      o.status = accil_pkg::STAT_HALTED;
    end else if (r.req_type > accil_pkg::OP_LAST) begin
      o.status = accil_pkg::STAT_UNKNOWN;
      run_q    = 1'b0;
    end else if (r.req_type == accil_pkg::OP_DIV && b == 0) begin
      o.status = accil_pkg::STAT_DIVZERO;
      run_q    = 1'b0;
    end else begin
      case (r.req_type)
        accil_pkg::OP_LD:    a = b;
        accil_pkg::OP_LDN:   a = -b;
        accil_pkg::OP_ST:    o.print_kind = accil_pkg::PRINT_VALUE;
        accil_pkg::OP_STN:   o.print_kind = accil_pkg::PRINT_MINUS;
        accil_pkg::OP_READ:  a = r.read_value;
        accil_pkg::OP_PRINT: o.print_kind = accil_pkg::PRINT_VALUE;
        accil_pkg::OP_AND:   a = a & b;
        accil_pkg::OP_NAND:  a = ~(a & b);
        accil_pkg::OP_OR:    a = a | b;
        accil_pkg::OP_NOR:   a = ~(a | b);
        accil_pkg::OP_XOR:   a = a ^ b;
        accil_pkg::OP_XNOR:  a = ~(a ^ b);
        accil_pkg::OP_NOT:   a = ~a;
        accil_pkg::OP_ADD:   a = a + b;
        accil_pkg::OP_SUB:   a = a - b;
        accil_pkg::OP_MUL:   a = a * b;
        accil_pkg::OP_DIV: begin
          ma = a[63] ? -a : a;
          mb = b[63] ? -b : b;
          q  = ma / mb;
          a  = (a[63] ^ b[63]) ? -q : q;
        end
        accil_pkg::OP_GT:    a = {63'd0, a > b};
        accil_pkg::OP_GE:    a = {63'd0, a >= b};
        accil_pkg::OP_EQ:    a = {63'd0, a == b};
        accil_pkg::OP_NE:    a = {63'd0, a != b};
        accil_pkg::OP_LE:    a = {63'd0, a <= b};
        accil_pkg::OP_LT:    a = {63'd0, a < b};
        accil_pkg::OP_JMP:   take = 1'b1;
        accil_pkg::OP_JMPC:  take = (a == 1);
        accil_pkg::OP_JMPCN: take = (a == 0);
        accil_pkg::OP_RET:   run_q = 1'b0;
        accil_pkg::OP_RETC:  if (a == 1) run_q = 1'b0;
        accil_pkg::OP_RETCN: if (a == 0) run_q = 1'b0;
        default: ;
      endcase
      pc_q = take ? pc_q + b[15:0] : pc_q + 16'd1;
      if (!run_q) o.status = accil_pkg::STAT_RET;
      acc_q = a;
    end
    o.print_value = (o.print_kind != accil_pkg::PRINT_NONE) ? acc_q : '0;
    o.next_pc     = pc_q;
    o.acc_value   = acc_q;
    return o;
  endfunction

  function automatic logic [63:0] pick_word();
    logic signed [63:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        v = $urandom_range(0, 16);
        v = v - 64'sd8;
      end
      3: begin
        case ($urandom_range(0, 4))
          0:       v = ACC_MAX;
          1:       v = ACC_MIN;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      4:       v = acc_q;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // never halts: returns and divides are steered to their non-halting forms
  function automatic accil_pkg::req_t rand_req(input logic after_cmp);
    accil_pkg::req_t r;
    if (after_cmp && $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 3))
        0:       r.req_type = accil_pkg::OP_JMPC;
        1:       r.req_type = accil_pkg::OP_JMPCN;
        2:       r.req_type = accil_pkg::OP_RETC;
        default: r.req_type = accil_pkg::OP_RETCN;
      endcase
    end else begin
      r.req_type = 5'($urandom_range(0, accil_pkg::OP_LAST));
    end
    r.operand    = pick_word();
    r.read_value = pick_word();
    if (r.req_type == accil_pkg::OP_RET) begin
      r.req_type = (acc_q == 1) ? accil_pkg::OP_RETCN : accil_pkg::OP_RETC;
    end
    if (r.req_type == accil_pkg::OP_RETC && acc_q == 1) r.req_type = accil_pkg::OP_RETCN;
    else if (r.req_type == accil_pkg::OP_RETCN && acc_q == 0) r.req_type = accil_pkg::OP_RETC;
    if (r.req_type == accil_pkg::OP_DIV && r.operand == 0) r.operand = 1;
    return r;
  endfunction

  task automatic add_row(input logic [4:0] op, input logic [63:0] arg,
                         input logic [63:0] rd, input logic pin,
                         input logic [1:0] kind, input logic [63:0] pv,
                         input logic [15:0] pc, input logic [63:0] acc);
    instr_row_t row;
    row.req.req_type    = op;
    row.req.operand     = arg;
    row.req.read_value  = rd;
    row.pinned          = pin;
    row.rsp.status      = accil_pkg::STAT_OK;
    row.rsp.print_kind  = kind;
    row.rsp.print_value = pv;
    row.rsp.next_pc     = pc;
    row.rsp.acc_value   = acc;
    dir_tbl.push_back(row);
  endtask

  task automatic send_instr(input accil_pkg::req_t r, input logic pin,
                            input accil_pkg::rsp_t pin_rsp);
    accil_pkg::rsp_t got;
    if (!calm && $urandom_range(0, 99) < tx_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    got = execute_instr(r);
    pending_rsp_q.push_back(pin ? pin_rsp : got);
  endtask

  initial begin : tx_side
    accil_pkg::req_t r;
    logic after_cmp;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_req   <= '0;
    after_cmp = 1'b0;

    add_row(accil_pkg::OP_LD,    ACC_MAX, 0, 1, accil_pkg::PRINT_NONE,  0,       1,  ACC_MAX);
    add_row(accil_pkg::OP_ST,    0,       0, 1, accil_pkg::PRINT_VALUE, ACC_MAX, 2,  ACC_MAX);
    add_row(accil_pkg::OP_ADD,   1,       0, 1, accil_pkg::PRINT_NONE,  0,       3,  ACC_MIN);
    add_row(accil_pkg::OP_STN,   0,       0, 1, accil_pkg::PRINT_MINUS, ACC_MIN, 4,  ACC_MIN);
    add_row(accil_pkg::OP_SUB,   1,       0, 1, accil_pkg::PRINT_NONE,  0,       5,  ACC_MAX);
    add_row(accil_pkg::OP_LDN,   ACC_MIN, 0, 1, accil_pkg::PRINT_NONE,  0,       6,  ACC_MIN);
    add_row(accil_pkg::OP_DIV,   -1,      0, 1, accil_pkg::PRINT_NONE,  0,       7,  ACC_MIN);
    add_row(accil_pkg::OP_MUL,   -1,      0, 1, accil_pkg::PRINT_NONE,  0,       8,  ACC_MIN);
    add_row(accil_pkg::OP_READ,  0, ACC_MAX, 1, accil_pkg::PRINT_NONE,  0,       9,  ACC_MAX);
    add_row(accil_pkg::OP_PRINT, 0,       0, 1, accil_pkg::PRINT_VALUE, ACC_MAX, 10, ACC_MAX);
    add_row(accil_pkg::OP_DIV,   -2,      0, 1, accil_pkg::PRINT_NONE,  0,       11,
            64'hC000_0000_0000_0001);
    add_row(accil_pkg::OP_READ,  -1, ACC_MIN, 1, accil_pkg::PRINT_NONE, 0,       12, ACC_MIN);
    add_row(accil_pkg::OP_AND, 64'hFFFF_0000_FFFF_0000, 0, 0, accil_pkg::PRINT_NONE, 0, 0, 0);
    add_row(accil_pkg::OP_NAND, 64'h0F0F_0F0F_0F0F_0F0F, 0, 0, accil_pkg::PRINT_NONE, 0, 0, 0);
    add_row(accil_pkg::OP_OR,    1,       0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_NOR,   0,       0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_XOR,   -1,      0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_XNOR,  0,       0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_NOT,   0,       0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_GT,    0,       0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_GE,    0,       0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_EQ,    1,       0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_JMPC,  5,       0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_RETCN, 0,       0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_NE,    1,       0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_JMPCN, -3,      0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_RETC,  0,       0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_LE,    -1,      0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_LT,    1,       0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);
    add_row(accil_pkg::OP_JMP,   -200,    0, 0, accil_pkg::PRINT_NONE,  0,       0,  0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) send_instr(dir_tbl[i].req, dir_tbl[i].pinned, dir_tbl[i].rsp);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) tx_rate = 25 * $urandom_range(0, 2);
      if (i == 300) begin
        // receiver holds off while requests keep coming
        hold_ticket <= hold_ticket + 1;
        tx_rate = 0;
      end
      if (i == 650) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_rsp_q.size() != 0);
      end
      if (i == N_RANDOM - 150) calm <= 1'b1;
      r = rand_req(after_cmp);
      after_cmp = (r.req_type >= accil_pkg::OP_GT && r.req_type <= accil_pkg::OP_LT);
      send_instr(r, 1'b0, '0);
    end

    r = rand_req(1'b0);
    case ($urandom_range(0, 4))
      0: r.req_type = accil_pkg::OP_RET;
      1: r.req_type = accil_pkg::OP_LAST + 5'd1 + 5'($urandom_range(0, 2));
      2: begin
        r.req_type = accil_pkg::OP_DIV;
        r.operand  = 0;
      end
      3: begin
        send_instr('{req_type: accil_pkg::OP_LD, operand: 1, read_value: 0}, 1'b0, '0);
        r.req_type = accil_pkg::OP_RETC;
      end
      default: begin
        send_instr('{req_type: accil_pkg::OP_LD, operand: 0, read_value: 0}, 1'b0, '0);
        r.req_type = accil_pkg::OP_RETCN;
      end
    endcase
    send_instr(r, 1'b0, '0);

    // ignored while halted
    repeat (4) begin
      r.req_type   = 5'($urandom_range(0, 31));
      r.operand    = {$urandom, $urandom};
      r.read_value = {$urandom, $urandom};
      send_instr(r, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : rx_side
    int seen;
    int rx_rate;
    int n;
    seen    = 0;
    rx_rate = 20;
    n       = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      n++;
      if (n % 97 == 0) rx_rate = 25 * $urandom_range(0, 2);
      if (hold_ticket != seen) begin
        seen = hold_ticket;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rx_rate) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin : rsp_check
    accil_pkg::rsp_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_rsp_q.size() == 0) begin
          $error("unexpected response: status %0d acc %0d", out_rsp.status, out_rsp.acc_value);
          fails++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (out_rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp.status);
            fails++;
          end
          if (out_rsp.print_kind !== want.print_kind) begin
            $error("print_kind: expected %0d, got %0d", want.print_kind, out_rsp.print_kind);
            fails++;
          end
          if (out_rsp.print_value !== want.print_value) begin
            $error("print_value: expected %0d, got %0d", want.print_value,
                   out_rsp.print_value);
            fails++;
          end
          if (out_rsp.next_pc !== want.next_pc) begin
            $error("next_pc: expected %0d, got %0d", want.next_pc, out_rsp.next_pc);
            fails++;
          end
          if (out_rsp.acc_value !== want.acc_value) begin
            $error("acc_value: expected %0d, got %0d", want.acc_value, out_rsp.acc_value);
            fails++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
rtl/core/accil_pkg.sv
rtl/core/accil_muldiv.sv
rtl/core/accumulator_il_instruction_executor_top.sv
dv/accumulator_il_instruction_executor_top_tb.sv
